FILE: hw/rtl/fbre_pkg.sv
// Shared types and constants for the framebuffer raster engine.
// Depends on nothing; the top level and fbre_pixel import it.
`default_nettype none
package fbre_pkg;

  // Command codes carried by the func field.
  typedef enum logic [2:0] {
    FUNC_CLEAR  = 3'd0,
    FUNC_PLOT   = 3'd1,
    FUNC_RECT   = 3'd2,
    FUNC_CIRCLE = 3'd3,
    FUNC_DISC   = 3'd4,
    FUNC_READ   = 3'd5
  } func_e;

  // Configuration register indexes.
  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  localparam logic [31:0] BLANK_PIXEL = 32'h0000_0000;

  // Engine states.
  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_RECT,
    ST_MID_OCT,
    ST_MID_STEP,
    ST_AND_OCT,
    ST_AND_STEP,
    ST_READ_WAIT,
    ST_READ_DATA,
    ST_DONE
  } state_e;

  // Write request from the drawing sequencer to the pixel unit.
  typedef struct packed {
    logic               valid;
    logic signed [13:0] col;
    logic signed [13:0] row;
  } px_req_t;

endpackage
`default_nettype wire

FILE: hw/rtl/framebuffer_raster_engine_top.sv
// Top level of the framebuffer raster engine: command sequencer, pixel unit
// and frame store. Depends on fbre_pkg, fbre_pixel and fbre_ram.
`default_nettype none
// The block draws into a 32-bit pixel store of MAX_WIDTH*MAX_HEIGHT words
// and takes one command at a time; each command returns exactly one word.
// After reset a clearing pass writes black to every store entry, one per
// cycle, so the first command is taken only after that pass.
// The single store port sets the rate: at most one pixel a cycle. Beyond
// accepting a command and offering its word, clear writes every entry of the
// width*height screen and a rectangle its clipped area; a circle outline
// writes eight mirrored pixels and one update per step of the midpoint loop,
// a filled circle the like for every ring, plot eight writes and one update,
// a read a wait and a data state. A stalled result holds the engine.
module framebuffer_raster_engine_top import fbre_pkg::*; #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [8:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  func_i,
  input  logic [9:0]  x_pos_i,
  input  logic [9:0]  y_pos_i,
  input  logic [9:0]  extent_a_i,
  input  logic [9:0]  extent_b_i,
  input  logic [31:0] color_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] read_color_o,
  output logic        read_hit_o
);

  localparam int Depth = MAX_WIDTH * MAX_HEIGHT;
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW  = AddrW + 1;

  state_e state_q, state_d;
  logic [8:0] scr_w_q, scr_h_q;
  logic [12:0] eff_w, eff_h;
  logic [CntW-1:0] cnt_q, cnt_d, clr_n;
  logic [2:0] oct_q, oct_d;
  logic signed [13:0] cx_q, cy_q, a_q, a_d, b_q, b_d, e_q, e_d, r_q, r_d;
  logic signed [13:0] i_q, i_d, j_q, j_d, rw_q, rh_q, rw_d, rh_d;
  logic [31:0] color_q, rcolor_q, rcolor_d;
  logic hit_q, hit_d;
  px_req_t req;
  logic px_hit;
  logic [AddrW-1:0] px_addr, ram_addr;
  logic ram_we;
  logic [31:0] ram_wdata, ram_rdata;
  logic signed [13:0] pa, pb, wl, hl, ea_s, eb_s;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scr_w_q <= 9'd256;
      scr_h_q <= 9'd256;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CFG_WIDTH) scr_w_q <= cfg_wdata_i;
      else                          scr_h_q <= cfg_wdata_i;
    end
  end

  // Screen limited to the store.
  always_comb begin
    eff_w = ({4'd0, scr_w_q} > 13'(MAX_WIDTH))  ? 13'(MAX_WIDTH)  : {4'd0, scr_w_q};
    eff_h = ({4'd0, scr_h_q} > 13'(MAX_HEIGHT)) ? 13'(MAX_HEIGHT) : {4'd0, scr_h_q};
    clr_n = CntW'(eff_w * eff_h);
    ea_s  = {4'd0, extent_a_i};
    eb_s  = {4'd0, extent_b_i};
    wl    = $signed({1'b0, eff_w}) - $signed({4'd0, x_pos_i});
    hl    = $signed({1'b0, eff_h}) - $signed({4'd0, y_pos_i});
  end

  // Octant offsets: (pa,pb) and oct pick one of eight mirrored pixels.
  always_comb begin
    pa = (oct_q[0]) ? b_q : a_q;
    pb = (oct_q[0]) ? a_q : b_q;
    req.valid = 1'b0;
    req.col   = cx_q + (oct_q[1] ? -pa : pa);
    req.row   = cy_q + (oct_q[2] ? -pb : pb);
    case (state_q)
      ST_MID_OCT, ST_AND_OCT: req.valid = 1'b1;
      ST_RECT: begin
        req.valid = 1'b1;
        req.col   = cx_q + i_q;
        req.row   = cy_q + j_q;
      end
      ST_READ_WAIT: begin
        req.valid = 1'b1;
        req.col   = cx_q;
        req.row   = cy_q;
      end
      default: ;
    endcase
  end

  fbre_pixel #(.AddrW(AddrW)) u_pixel (
    .eff_w_i (eff_w),
    .eff_h_i (eff_h),
    .req_i   (req),
    .hit_o   (px_hit),
    .addr_o  (px_addr)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_INIT:  if (cnt_q == CntW'(Depth - 1)) state_d = ST_IDLE;
      ST_IDLE: begin
        if (in_valid_i) begin
          case (func_i)
            FUNC_CLEAR:  state_d = (clr_n == '0) ? ST_DONE : ST_CLEAR;
            FUNC_PLOT:   state_d = ST_AND_OCT;
            FUNC_RECT:   state_d = ST_RECT;
            FUNC_CIRCLE: state_d = ST_MID_OCT;
            FUNC_DISC:   state_d = ST_AND_OCT;
            FUNC_READ:   state_d = ST_READ_WAIT;
            default:     state_d = ST_DONE;
          endcase
        end
      end
      ST_CLEAR:     if (cnt_q == clr_n - 1'b1) state_d = ST_DONE;
      ST_RECT:      if (rw_q <= 0 || rh_q <= 0 ||
                        (i_q == rw_q - 1 && j_q == rh_q - 1)) state_d = ST_DONE;
      ST_MID_OCT:   if (oct_q == 3'd7) state_d = ST_MID_STEP;
      ST_MID_STEP:  state_d = (a_d >= b_d) ? ST_MID_OCT : ST_DONE;
      ST_AND_OCT:   if (oct_q == 3'd7) state_d = ST_AND_STEP;
      ST_AND_STEP:  state_d = (b_d >= a_d || r_q > 0) ? ST_AND_OCT : ST_DONE;
      ST_READ_WAIT: state_d = ST_READ_DATA;
      ST_READ_DATA: state_d = ST_DONE;
      ST_DONE:      if (!out_stall_i) state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  // Datapath and store port.
  always_comb begin
    cnt_d = cnt_q; oct_d = oct_q; a_d = a_q; b_d = b_q; e_d = e_q; r_d = r_q;
    i_d = i_q; j_d = j_q; rw_d = rw_q; rh_d = rh_q;
    rcolor_d = rcolor_q; hit_d = hit_q;
    ram_we = 1'b0; ram_addr = px_addr; ram_wdata = color_q;
    case (state_q)
      ST_INIT: begin
        ram_we = 1'b1; ram_addr = cnt_q[AddrW-1:0]; ram_wdata = BLANK_PIXEL;
        cnt_d = cnt_q + 1'b1;
      end
      ST_IDLE: begin
        cnt_d = '0; oct_d = '0; i_d = '0; j_d = '0;
        rcolor_d = BLANK_PIXEL; hit_d = 1'b0;
        rw_d = (ea_s > wl) ? wl : ea_s;
        rh_d = (eb_s > hl) ? hl : eb_s;
        if (func_i == FUNC_CIRCLE) begin
          a_d = ea_s; b_d = '0; e_d = '0;
        end else if (func_i == FUNC_DISC) begin
          a_d = '0; b_d = ea_s; e_d = ea_s - 14'sd1; r_d = ea_s;
        end else begin
          a_d = '0; b_d = '0; e_d = -14'sd1; r_d = '0;
        end
      end
      ST_CLEAR: begin
        ram_we = 1'b1; ram_addr = cnt_q[AddrW-1:0];
        cnt_d = cnt_q + 1'b1;
      end
      ST_RECT: begin
        ram_we = px_hit && rw_q > 0 && rh_q > 0;
        if (i_q == rw_q - 1) begin
          i_d = '0; j_d = j_q + 14'sd1;
        end else begin
          i_d = i_q + 14'sd1;
        end
      end
      ST_MID_OCT, ST_AND_OCT: begin
        ram_we = px_hit; oct_d = oct_q + 1'b1;
      end
      ST_MID_STEP: begin
        // Midpoint step in (b,a) order: a_q holds a, b_q holds b.
        b_d = b_q; a_d = a_q; e_d = e_q;
        if (e_q <= 0) begin
          b_d = b_q + 14'sd1; e_d = e_q + (b_d <<< 1) + 14'sd1;
        end
        if (e_d > 0) begin
          a_d = a_q - 14'sd1; e_d = e_d - (a_d <<< 1) - 14'sd1;
        end
      end
      ST_AND_STEP: begin
        if (2 * a_q <= e_q) begin
          e_d = e_q - (a_q <<< 1) - 14'sd1; a_d = a_q + 14'sd1;
        end else if (e_q < 2 * (r_q - b_q)) begin
          e_d = e_q + (b_q <<< 1) - 14'sd1; b_d = b_q - 14'sd1;
        end else begin
          e_d = e_q - ((a_q - b_q + 14'sd1) <<< 1);
          b_d = b_q - 14'sd1; a_d = a_q + 14'sd1;
        end
        if (!(b_d >= a_d)) begin
          r_d = r_q - 14'sd1; a_d = '0; b_d = r_q - 14'sd1; e_d = r_q - 14'sd2;
        end
      end
      ST_READ_WAIT: hit_d = px_hit;
      ST_READ_DATA: rcolor_d = hit_q ? ram_rdata : BLANK_PIXEL;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
      cnt_q   <= '0;
      oct_q   <= '0;
      hit_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      oct_q   <= oct_d;
      hit_q   <= hit_d;
    end
  end

  // Command payload registers.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE) begin
      cx_q    <= {4'd0, x_pos_i};
      cy_q    <= {4'd0, y_pos_i};
      color_q <= color_i;
    end
    a_q <= a_d; b_q <= b_d; e_q <= e_d; r_q <= r_d;
    i_q <= i_d; j_q <= j_d; rw_q <= rw_d; rh_q <= rh_d;
    rcolor_q <= rcolor_d;
  end

  fbre_ram #(.Width(32), .Depth(Depth)) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // Handshake outputs.
  always_comb begin
    in_stall_o   = (state_q != ST_IDLE);
    out_valid_o  = (state_q == ST_DONE);
    read_color_o = rcolor_q;
    read_hit_o   = hit_q;
  end

`ifndef SYNTHESIS
  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE || state_q == ST_DONE) |-> !ram_we)
    else $error("store written while no command runs");
  a_hit_color: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !read_hit_o) |-> (read_color_o == BLANK_PIXEL))
    else $error("nonzero color without a read hit");
  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i) |=> !out_valid_o)
    else $error("result repeated");
`endif

endmodule
`default_nettype wire

FILE: hw/rtl/fbre_ram.sv
// Generic single-port synchronous RAM with a registered read.
// Depends on nothing.
`default_nettype none
module fbre_ram #(
  parameter int Width = 32,
  parameter int Depth = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // One access per cycle, read data registered.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule
`default_nettype wire

FILE: hw/rtl/fbre_pixel.sv
// Pixel clip and address unit: checks a signed coordinate against the screen
// and forms the store address width*row+col. Depends on fbre_pkg.
`default_nettype none
module fbre_pixel import fbre_pkg::*; #(
  parameter int AddrW = 16
) (
  input  logic [12:0]       eff_w_i,
  input  logic [12:0]       eff_h_i,
  input  px_req_t           req_i,
  output logic              hit_o,
  output logic [AddrW-1:0]  addr_o
);

  logic [25:0] prod;

  // Clip against the screen, then one narrow multiply-add for the address.
  always_comb begin
    hit_o = req_i.valid && !req_i.col[13] && !req_i.row[13]
            && (req_i.col[12:0] < eff_w_i) && (req_i.row[12:0] < eff_h_i);
    prod   = eff_w_i * req_i.row[12:0] + {13'd0, req_i.col[12:0]};
    addr_o = prod[AddrW-1:0];
  end

endmodule
`default_nettype wire
